### sv/sdp_pkg.sv
package sdp_pkg;

  localparam int unsigned MaxFrameBytes = 4096;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned SessionBytes  = 4;
  localparam int unsigned HeaderBytes   = 8;
  localparam int unsigned EntryBytes    = 16;
  localparam int unsigned EntryLastPos  = 15;
  localparam int unsigned OutDataW      = 160;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT_HEADER = 3'd1,
    ST_BAD_LENGTH   = 3'd2,
    ST_MISMATCH     = 3'd3,
    ST_UNKNOWN_TYPE = 3'd4,
    ST_RESERVED_NZ  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_FIND_TYPE    = 2'd0,
    REG_OFFER_TYPE   = 2'd1,
    REG_SUB_TYPE     = 2'd2,
    REG_SUB_ACK_TYPE = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] find_code;
    logic [7:0] offer_code;
    logic [7:0] sub_code;
    logic [7:0] sub_ack_code;
  } type_codes_t;

  typedef struct packed {
    logic [7:0]  entry_type;
    logic [15:0] svc_id;
    logic [15:0] inst_id;
    logic [7:0]  major_ver;
    logic [23:0] ttl;
    logic [31:0] minor_ver;
    logic [15:0] evgrp_id;
  } entry_t;

  typedef struct packed {
    logic    has_entry;
    logic    has_status;
    entry_t  entry;
    status_e entry_status;
    logic [31:0] session;
    status_e frame_status;
  } item_t;

endpackage

### sv/sdp_front.sv
module sdp_front #(
  parameter int unsigned MAX_FRAME_BYTES = sdp_pkg::MaxFrameBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_end_i,
  input  sdp_pkg::type_codes_t codes_i,
  output logic                push_o,
  output sdp_pkg::item_t      item_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic [31:0]     session_q, session_d;
  logic [31:0]     length_q, length_d;
  sdp_pkg::status_e fee_q, fee_d;
  logic [7:0]      entry_q [sdp_pkg::EntryLastPos];

  logic            sat;
  logic [3:0]      pos;
  logic            in_body;
  logic            entry_done;
  sdp_pkg::status_e entry_st;
  sdp_pkg::status_e frame_st;
  sdp_pkg::entry_t entry;
  logic            known;
  logic [32:0]     expected_len;

  assign sat        = (cnt_q == CntW'(MAX_FRAME_BYTES));
  assign pos        = cnt_q[3:0] ^ 4'(sdp_pkg::HeaderBytes);
  assign in_body    = (cnt_q >= CntW'(sdp_pkg::HeaderBytes));
  assign entry_done = in_accept_i && !sat && in_body && (pos == 4'(sdp_pkg::EntryLastPos));

  always_comb begin
    entry.entry_type = entry_q[0];
    entry.svc_id     = {entry_q[2], entry_q[3]};
    entry.inst_id    = {entry_q[4], entry_q[5]};
    entry.major_ver  = entry_q[6];
    entry.ttl        = {entry_q[7], entry_q[8], entry_q[9]};
    entry.minor_ver  = {entry_q[10], entry_q[11], entry_q[12], entry_q[13]};
    entry.evgrp_id   = {entry_q[14], data_byte_i};
  end

  assign known = (entry_q[0] == codes_i.find_code) || (entry_q[0] == codes_i.offer_code) ||
                 (entry_q[0] == codes_i.sub_code) || (entry_q[0] == codes_i.sub_ack_code);

  always_comb begin
    priority if (!known) begin
      entry_st = sdp_pkg::ST_UNKNOWN_TYPE;
    end else if (entry_q[1] != 8'd0) begin
      entry_st = sdp_pkg::ST_RESERVED_NZ;
    end else begin
      entry_st = sdp_pkg::ST_OK;
    end
  end

  always_comb begin
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    session_d = session_q;
    length_d  = length_q;
    fee_d     = fee_q;
    if (in_accept_i) begin
      if (sat) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q < CntW'(sdp_pkg::SessionBytes)) begin
          session_d = {session_q[23:0], data_byte_i};
        end else if (!in_body) begin
          length_d = {length_q[23:0], data_byte_i};
        end
        if (entry_done && (fee_q == sdp_pkg::ST_OK)) begin
          fee_d = entry_st;
        end
      end
    end
  end

  assign expected_len = 33'(sdp_pkg::HeaderBytes) + {1'b0, length_d};

  always_comb begin
    priority if (cnt_d < CntW'(sdp_pkg::HeaderBytes)) begin
      frame_st = sdp_pkg::ST_SHORT_HEADER;
    end else if ((length_d == 32'd0) || (length_d[3:0] != 4'd0)) begin
      frame_st = sdp_pkg::ST_BAD_LENGTH;
    end else if (ovf_d || (33'(cnt_d) != expected_len)) begin
      frame_st = sdp_pkg::ST_MISMATCH;
    end else begin
      frame_st = fee_d;
    end
  end

  always_comb begin
    item_o.has_entry    = entry_done;
    item_o.has_status   = frame_end_i;
    item_o.entry        = entry;
    item_o.entry_status = entry_st;
    item_o.session      = session_d;
    item_o.frame_status = frame_st;
  end

  assign push_o = in_accept_i && (entry_done || frame_end_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      session_q <= '0;
      length_q  <= '0;
      fee_q     <= sdp_pkg::ST_OK;
    end else if (in_accept_i && frame_end_i) begin
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      session_q <= '0;
      length_q  <= '0;
      fee_q     <= sdp_pkg::ST_OK;
    end else begin
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      session_q <= session_d;
      length_q  <= length_d;
      fee_q     <= fee_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i && !sat && in_body && (pos != 4'(sdp_pkg::EntryLastPos))) begin
      entry_q[pos] <= data_byte_i;
    end
  end

endmodule

### sv/sdp_queue.sv
module sdp_queue #(
  parameter int unsigned DEPTH = sdp_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sdp_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output sdp_pkg::item_t item_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  sdp_pkg::item_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      unique case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### sv/sdp_back.sv
module sdp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  sdp_pkg::item_t                q_item_i,
  output logic                          q_pop_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [sdp_pkg::OutDataW-1:0]  m_data_o,
  output logic                          m_kind_o,
  output logic                          m_last_o
);

  logic                         valid_q;
  logic [sdp_pkg::OutDataW-1:0] data_q, data_d;
  logic                         kind_q, kind_d;
  logic                         phase_q;
  logic                         load;
  logic                         send_entry;
  sdp_pkg::entry_t              ent;
  sdp_pkg::status_e             st;
  logic [31:0]                  sess;

  assign load       = q_valid_i && (!valid_q || m_ready_i);
  assign send_entry = q_item_i.has_entry && !phase_q;
  assign q_pop_o    = load && !(send_entry && q_item_i.has_status);

  always_comb begin
    ent    = send_entry ? q_item_i.entry : '0;
    st     = send_entry ? q_item_i.entry_status : q_item_i.frame_status;
    sess   = send_entry ? 32'd0 : q_item_i.session;
    kind_d = !send_entry;
    data_d = {5'd0, st, sess, ent.evgrp_id, ent.minor_ver, ent.ttl,
              ent.major_ver, ent.inst_id, ent.svc_id, ent.entry_type};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        phase_q <= send_entry && q_item_i.has_status;
      end else if (m_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
      kind_q <= kind_d;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_kind_o  = kind_q;
  assign m_last_o  = kind_q;

endmodule

### sv/sd_payload_parser.sv
// Service discovery payload parser. Payload bytes arrive one per transfer on the slave
// stream, with tlast on the final byte; the first eight bytes are the reboot/session word
// and the entries length, the rest is cut into 16-byte entries. Each complete entry yields
// one result (tuser low) with its decoded fields and entry status, and the final byte
// yields a status result (tuser and tlast high) with the frame status; a consumer drops
// the entries of a frame whose status is non-zero. The block takes one byte per cycle
// while the queue is not full; a four-deep queue separates the byte counter and field
// capture from the output register, which sends one result per cycle while the consumer
// is ready; a byte ending both an entry and the frame yields two results. Type codes must
// be written through the APB port only while the block is idle; no logic enforces it.
module sd_payload_parser #(
  parameter int unsigned MAX_FRAME_BYTES = sdp_pkg::MaxFrameBytes,
  parameter int unsigned QUEUE_DEPTH     = sdp_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // data_byte[7:0]
  input  logic [7:0]                   s_axis_tdata,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // entry_type[7:0], svc_id[23:8], inst_id[39:24], major_ver[47:40],
  // ttl[71:48], minor_ver[103:72], evgrp_id[119:104],
  // session[151:120], status[154:152], zero fill[159:155]
  output logic [sdp_pkg::OutDataW-1:0] m_axis_tdata,
  // result_kind[0]
  output logic                         m_axis_tuser,
  output logic                         m_axis_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  sdp_pkg::type_codes_t codes_q;
  sdp_pkg::reg_idx_e    reg_idx;
  sdp_pkg::item_t       push_item, head_item;
  logic                 in_accept;
  logic                 push, full, head_valid, pop;

  assign pready  = 1'b1;
  assign reg_idx = sdp_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.find_code    <= 8'd0;
      codes_q.offer_code   <= 8'd1;
      codes_q.sub_code     <= 8'd6;
      codes_q.sub_ack_code <= 8'd7;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        sdp_pkg::REG_FIND_TYPE:    codes_q.find_code    <= pwdata[7:0];
        sdp_pkg::REG_OFFER_TYPE:   codes_q.offer_code   <= pwdata[7:0];
        sdp_pkg::REG_SUB_TYPE:     codes_q.sub_code     <= pwdata[7:0];
        sdp_pkg::REG_SUB_ACK_TYPE: codes_q.sub_ack_code <= pwdata[7:0];
        default:                   codes_q              <= codes_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sdp_pkg::REG_FIND_TYPE:    prdata = {24'd0, codes_q.find_code};
      sdp_pkg::REG_OFFER_TYPE:   prdata = {24'd0, codes_q.offer_code};
      sdp_pkg::REG_SUB_TYPE:     prdata = {24'd0, codes_q.sub_code};
      sdp_pkg::REG_SUB_ACK_TYPE: prdata = {24'd0, codes_q.sub_ack_code};
      default:                   prdata = 32'd0;
    endcase
  end

  assign s_axis_tready = !full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  sdp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .data_byte_i (s_axis_tdata),
    .frame_end_i (s_axis_tlast),
    .codes_i     (codes_q),
    .push_o      (push),
    .item_o      (push_item)
  );

  sdp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .valid_o (head_valid),
    .pop_i   (pop),
    .item_o  (head_item)
  );

  sdp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (head_valid),
    .q_item_i  (head_item),
    .q_pop_o   (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_kind_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue written while full");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_status_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[119:0] == '0))
    else $error("status result carries entry fields");

  a_entry_session_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[151:120] == '0) && !m_axis_tlast)
    else $error("entry result carries session word or end flag");

endmodule

### dv/sdp_checker.sv
module sdp_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,
  input  logic                         s_axis_tlast,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [sdp_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         m_axis_tuser,
  input  logic                         m_axis_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  input  logic [31:0]                  prdata,
  input  logic                         pready,
  output int                           mismatches_o,
  output int                           outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic             kind;
    sdp_pkg::entry_t  entry;
    logic [31:0]      session;
    sdp_pkg::status_e status;
    logic             last;
  } sd_result_t;

  logic [7:0]       type_code [4];
  logic [12:0]      byte_cnt;
  logic             cnt_saturated;
  logic [31:0]      session_word;
  logic [31:0]      entries_len;
  logic [7:0]       entry_buf [sdp_pkg::EntryLastPos];
  sdp_pkg::status_e first_entry_err;
  sd_result_t       predicted_results [$];

  function automatic void clear_frame();
    byte_cnt        = '0;
    cnt_saturated   = 1'b0;
    session_word    = '0;
    entries_len     = '0;
    first_entry_err = sdp_pkg::ST_OK;
  endfunction

  function automatic sdp_pkg::status_e classify_entry(logic [7:0] etype, logic [7:0] rsv);
    if (etype != type_code[sdp_pkg::REG_FIND_TYPE] &&
        etype != type_code[sdp_pkg::REG_OFFER_TYPE] &&
        etype != type_code[sdp_pkg::REG_SUB_TYPE] &&
        etype != type_code[sdp_pkg::REG_SUB_ACK_TYPE]) begin
      return sdp_pkg::ST_UNKNOWN_TYPE;
    end
    if (rsv != 8'h00) begin
      return sdp_pkg::ST_RESERVED_NZ;
    end
    return sdp_pkg::ST_OK;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic fin);
    sd_result_t  res;
    logic [12:0] pos;
    logic [3:0]  slot;
    if (byte_cnt >= sdp_pkg::MaxFrameBytes) begin
      cnt_saturated = 1'b1;
    end else begin
      pos      = byte_cnt;
      byte_cnt = byte_cnt + 13'd1;
      if (pos < sdp_pkg::SessionBytes) begin
        session_word = {session_word[23:0], b};
      end else if (pos < sdp_pkg::HeaderBytes) begin
        entries_len = {entries_len[23:0], b};
      end else begin
        // Position within the entry; the truncation is the modulo by the entry size.
        slot = 4'(pos - sdp_pkg::HeaderBytes);
        if (slot < sdp_pkg::EntryLastPos) begin
          entry_buf[slot] = b;
        end else begin
          res.kind             = 1'b0;
          res.session          = '0;
          res.last             = 1'b0;
          res.entry.entry_type = entry_buf[0];
          res.entry.svc_id     = {entry_buf[2], entry_buf[3]};
          res.entry.inst_id    = {entry_buf[4], entry_buf[5]};
          res.entry.major_ver  = entry_buf[6];
          res.entry.ttl        = {entry_buf[7], entry_buf[8], entry_buf[9]};
          res.entry.minor_ver  = {entry_buf[10], entry_buf[11], entry_buf[12],
                                  entry_buf[13]};
          res.entry.evgrp_id   = {entry_buf[14], b};
          res.status           = classify_entry(entry_buf[0], entry_buf[1]);
          if (first_entry_err == sdp_pkg::ST_OK) begin
            first_entry_err = res.status;
          end
          predicted_results.insert(predicted_results.size(), res);
        end
      end
    end
    if (fin) begin
      res.kind    = 1'b1;
      res.entry   = '0;
      res.session = session_word;
      res.last    = 1'b1;
      if (byte_cnt < sdp_pkg::HeaderBytes) begin
        res.status = sdp_pkg::ST_SHORT_HEADER;
      end else if (entries_len == '0 || entries_len[3:0] != 4'd0) begin
        res.status = sdp_pkg::ST_BAD_LENGTH;
      end else if (cnt_saturated ||
                   {20'b0, byte_cnt} != {1'b0, entries_len} + 33'(sdp_pkg::HeaderBytes)) begin
        res.status = sdp_pkg::ST_MISMATCH;
      end else begin
        res.status = first_entry_err;
      end
      predicted_results.insert(predicted_results.size(), res);
      clear_frame();
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches_o++;
      if (mismatches_o <= 10) begin
        $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
      end
    end
  endfunction

  function automatic void check_result();
    sd_result_t want;
    if (predicted_results.size() == 0) begin
      mismatches_o++;
      if (mismatches_o <= 10) begin
        $display("%0t result with nothing pending: tuser %0b, tdata %0h", $time,
                 m_axis_tuser, m_axis_tdata);
      end
      return;
    end
    want = predicted_results.pop_front();
    check_field("result_kind", 32'(want.kind), 32'(m_axis_tuser));
    check_field("entry_type", 32'(want.entry.entry_type), 32'(m_axis_tdata[7:0]));
    check_field("svc_id", 32'(want.entry.svc_id), 32'(m_axis_tdata[23:8]));
    check_field("inst_id", 32'(want.entry.inst_id), 32'(m_axis_tdata[39:24]));
    check_field("major_ver", 32'(want.entry.major_ver), 32'(m_axis_tdata[47:40]));
    check_field("ttl", 32'(want.entry.ttl), 32'(m_axis_tdata[71:48]));
    check_field("minor_ver", want.entry.minor_ver, m_axis_tdata[103:72]);
    check_field("evgrp_id", 32'(want.entry.evgrp_id), 32'(m_axis_tdata[119:104]));
    check_field("session", want.session, m_axis_tdata[151:120]);
    check_field("status", 32'(want.status), 32'(m_axis_tdata[154:152]));
    check_field("zero fill", 32'd0, 32'(m_axis_tdata[159:155]));
    check_field("last_result", 32'(want.last), 32'(m_axis_tlast));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_code[sdp_pkg::REG_FIND_TYPE]    = 8'd0;
      type_code[sdp_pkg::REG_OFFER_TYPE]   = 8'd1;
      type_code[sdp_pkg::REG_SUB_TYPE]     = 8'd6;
      type_code[sdp_pkg::REG_SUB_ACK_TYPE] = 8'd7;
      foreach (entry_buf[i]) begin
        entry_buf[i] = 8'h00;
      end
      clear_frame();
      predicted_results.delete();
      outstanding_o = 0;
    end else begin
      // Results leaving at this edge come from bytes accepted at earlier edges.
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          type_code[paddr[3:2]] = pwdata[7:0];
        end else begin
          check_field("prdata", {24'b0, type_code[paddr[3:2]]}, prdata);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, s_axis_tlast);
      end
      outstanding_o = predicted_results.size();
    end
  end

endmodule

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {
    FRAME_GOOD,
    FRAME_SHORT,
    FRAME_BAD_LENGTH,
    FRAME_EXTRA_ENTRY,
    FRAME_MISSING_ENTRY,
    FRAME_PARTIAL_ENTRY
  } frame_kind_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata;
  logic                         s_axis_tlast;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [sdp_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         m_axis_tlast;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [3:0]                   paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;
  int                           mismatches;
  int                           outstanding;

  bit                  quiet;
  int unsigned         hold_req;
  int unsigned         hold_left;
  int unsigned         bytes_sent;
  int unsigned         goal;
  logic [7:0]          codes [4];
  logic [7:0]          frame_q [$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sd_payload_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  sdp_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  task automatic push_byte(input logic [7:0] b, input logic fin);
    while (!quiet && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) begin
      push_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_access(input sdp_pkg::reg_idx_e idx, input logic wr,
                            input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_codes(input logic [7:0] find_v, input logic [7:0] offer_v,
                             input logic [7:0] sub_v, input logic [7:0] ack_v);
    codes[sdp_pkg::REG_FIND_TYPE]    = find_v;
    codes[sdp_pkg::REG_OFFER_TYPE]   = offer_v;
    codes[sdp_pkg::REG_SUB_TYPE]     = sub_v;
    codes[sdp_pkg::REG_SUB_ACK_TYPE] = ack_v;
    apb_access(sdp_pkg::REG_FIND_TYPE, 1'b1, find_v);
    apb_access(sdp_pkg::REG_OFFER_TYPE, 1'b1, offer_v);
    apb_access(sdp_pkg::REG_SUB_TYPE, 1'b1, sub_v);
    apb_access(sdp_pkg::REG_SUB_ACK_TYPE, 1'b1, ack_v);
    apb_access(sdp_pkg::REG_FIND_TYPE, 1'b0, 8'h00);
    apb_access(sdp_pkg::REG_OFFER_TYPE, 1'b0, 8'h00);
    apb_access(sdp_pkg::REG_SUB_TYPE, 1'b0, 8'h00);
    apb_access(sdp_pkg::REG_SUB_ACK_TYPE, 1'b0, 8'h00);
  endtask

  function automatic void add_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  function automatic void add_word(input logic [31:0] w);
    add_byte(w[31:24]);
    add_byte(w[23:16]);
    add_byte(w[15:8]);
    add_byte(w[7:0]);
  endfunction

  // Mostly known types with a clear reserved byte, so that frames reach an ok status.
  function automatic void add_entry();
    logic [7:0] etype;
    logic [7:0] rsv;
    etype = ($urandom_range(99) < 85) ? codes[$urandom_range(3)] : 8'($urandom);
    rsv   = ($urandom_range(99) < 85) ? 8'h00 : 8'($urandom);
    add_byte(etype);
    add_byte(rsv);
    repeat (14) add_byte(8'($urandom));
  endfunction

  function automatic frame_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return FRAME_GOOD;
    if (r < 73) return FRAME_SHORT;
    if (r < 81) return FRAME_BAD_LENGTH;
    if (r < 87) return FRAME_EXTRA_ENTRY;
    if (r < 93) return FRAME_MISSING_ENTRY;
    return FRAME_PARTIAL_ENTRY;
  endfunction

  function automatic void build_frame(input frame_kind_e kind, input int unsigned n_ent);
    logic [31:0] len;
    frame_q.delete();
    if (kind == FRAME_SHORT) begin
      repeat ($urandom_range(1, 7)) add_byte(8'($urandom));
      return;
    end
    len = 32'(sdp_pkg::EntryBytes * n_ent);
    if (kind == FRAME_BAD_LENGTH) begin
      case ($urandom_range(2))
        0: len = '0;
        1: len = len + 32'($urandom_range(1, 15));
        default: len = $urandom;
      endcase
    end
    add_word($urandom);
    add_word(len);
    if (kind == FRAME_EXTRA_ENTRY) n_ent++;
    if (kind == FRAME_MISSING_ENTRY) n_ent--;
    repeat (n_ent) add_entry();
    if (kind == FRAME_PARTIAL_ENTRY) begin
      repeat ($urandom_range(1, 15)) add_byte(8'($urandom));
    end
  endfunction

  task automatic run_frames(input int unsigned limit);
    while (bytes_sent < limit) begin
      build_frame(pick_kind(),
                  ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3));
      send_frame();
    end
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        m_axis_tready <= 1'b0;
        hold_left = hold_req;
        hold_req  = 0;
        while (hold_left != 0) begin
          @(posedge clk_i);
          hold_left--;
        end
      end else begin
        m_axis_tready <= quiet || $urandom_range(99) >= 20;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    quiet         = 1'b0;
    hold_req      = 0;
    bytes_sent    = 0;
    codes[sdp_pkg::REG_FIND_TYPE]    = 8'd0;
    codes[sdp_pkg::REG_OFFER_TYPE]   = 8'd1;
    codes[sdp_pkg::REG_SUB_TYPE]     = 8'd6;
    codes[sdp_pkg::REG_SUB_ACK_TYPE] = 8'd7;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(sdp_pkg::REG_FIND_TYPE, 1'b0, 8'h00);
    apb_access(sdp_pkg::REG_OFFER_TYPE, 1'b0, 8'h00);
    apb_access(sdp_pkg::REG_SUB_TYPE, 1'b0, 8'h00);
    apb_access(sdp_pkg::REG_SUB_ACK_TYPE, 1'b0, 8'h00);

    // A frame cut short inside the session word, then one entry of the find type with every
    // other field at its maximum and a set reserved byte.
    frame_q = '{8'hFF, 8'h00, 8'h80};
    send_frame();
    frame_q.delete();
    add_word(32'hFFFF_FFFF);
    add_word(32'(sdp_pkg::EntryBytes));
    add_byte(codes[sdp_pkg::REG_FIND_TYPE]);
    repeat (15) add_byte(8'hFF);
    send_frame();

    goal = bytes_sent;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase != 0) begin
        settle();
        case (phase)
          1: apply_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
          2: apply_codes(8'h00, 8'hFF, 8'h80, 8'h7F);
          4: apply_codes(8'h00, 8'h00, 8'h00, 8'h00);
          default: apply_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        endcase
      end
      quiet = (phase == 2);
      if (phase == 3) begin
        // The result side stalls for a long stretch while a long frame keeps coming.
        hold_req = 300;
        build_frame(FRAME_GOOD, 12);
        send_frame();
      end
      goal += 150;
      run_frames(goal);
    end

    settle();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("sd_payload_parser verification clean");
    end else begin
      $display("sd_payload_parser verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sd_payload_parser verification failed");
    $finish;
  end

endmodule
